@@ rtl/core/swm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character codes and register indexes of the schedule window matcher.
package swm_pkg;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_UPW   = 8'h57;
  localparam logic [7:0] CH_LOWW  = 8'h77;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [12:0] MIN_PER_HOUR = 13'd60;
  localparam logic [12:0] TEN          = 13'd10;

  localparam logic [1:0] REG_WEEKDAY = 2'd0;
  localparam logic [1:0] REG_MINUTE  = 2'd1;
  localparam logic [1:0] REG_DEFAULT = 2'd2;

  typedef enum logic [2:0] {
    PH_SCAN    = 3'b001,
    PH_MATCHED = 3'b010,
    PH_SKIP    = 3'b100
  } swm_phase_t;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [10:0] minute;
    logic        default_result;
  } swm_cfg_t;

  typedef struct packed {
    logic [2:0]  count;
    logic [12:0] acc;
    logic        ok;
  } swm_tacc_t;

  localparam swm_tacc_t TACC_RESET = '{count: 3'd0, acc: 13'd0, ok: 1'b1};

  typedef struct packed {
    logic       match_found;
    swm_phase_t phase;
    logic [1:0] colon_count;
    swm_tacc_t  start_time;
    swm_tacc_t  end_time;
    logic       error_seen;
  } swm_state_t;

  localparam swm_state_t STATE_RESET = '{
    match_found: 1'b0,
    phase:       PH_SCAN,
    colon_count: 2'd0,
    start_time:  TACC_RESET,
    end_time:    TACC_RESET,
    error_seen:  1'b0
  };

  typedef struct packed {
    logic in_window;
    logic spec_error;
  } swm_result_t;

endpackage

@@ rtl/core/swm_in_if.sv @@
`timescale 1ns / 1ps
// Input channel: one schedule text byte per transaction.
interface swm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] spec_byte;
  logic       last_byte;
  logic       spec_absent;

  modport source (output valid, output spec_byte, output last_byte, output spec_absent,
                  input ready);
  modport sink (input valid, input spec_byte, input last_byte, input spec_absent,
                output ready);
endinterface

@@ rtl/core/swm_out_if.sv @@
`timescale 1ns / 1ps
// Output channel: one match result per transaction.
interface swm_out_if;
  logic valid;
  logic ready;
  logic in_window;
  logic spec_error;

  modport source (output valid, output in_window, output spec_error, input ready);
  modport sink (input valid, input in_window, input spec_error, output ready);
endinterface

@@ rtl/core/swm_cfg.sv @@
`timescale 1ns / 1ps
// APB register bank holding weekday, minute and default result.
module swm_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output swm_pkg::swm_cfg_t cfg
);
  import swm_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_WEEKDAY: cfg.weekday        <= pwdata[2:0];
        REG_MINUTE:  cfg.minute         <= pwdata[10:0];
        REG_DEFAULT: cfg.default_result <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WEEKDAY: prdata = {29'd0, cfg.weekday};
      REG_MINUTE:  prdata = {21'd0, cfg.minute};
      REG_DEFAULT: prdata = {31'd0, cfg.default_result};
      default:     prdata = 32'd0;
    endcase
  end
endmodule

@@ rtl/core/swm_parser.sv @@
`timescale 1ns / 1ps
// Per-item parse state and its one-byte update, with item close and window test.
module swm_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           spec_byte,
  input  logic                 last_byte,
  input  logic                 spec_absent,
  input  swm_pkg::swm_cfg_t    cfg,
  output swm_pkg::swm_result_t result
);
  import swm_pkg::*;

  swm_state_t st;
  swm_state_t st_next;
  swm_state_t after_byte;
  swm_state_t after_last;

  function automatic swm_tacc_t take_time_char(swm_tacc_t t, logic [7:0] b);
    swm_tacc_t   r;
    logic [12:0] w;
    logic [12:0] d;
    r = t;
    d = {9'd0, b[3:0]};
    case (t.count[1:0])
      2'd0:    w = TEN * MIN_PER_HOUR;
      2'd1:    w = MIN_PER_HOUR;
      2'd2:    w = TEN;
      default: w = 13'd1;
    endcase
    if (t.count < 3'd4) begin
      if ((b inside {[CH_ZERO:CH_NINE]}) && t.ok) begin
        r.acc = t.acc + 13'(w * d);
      end else begin
        r.ok = 1'b0;
      end
      r.count = t.count + 3'd1;
    end
    return r;
  endfunction

  function automatic swm_state_t close_item(swm_state_t s_in, logic [10:0] minute);
    swm_state_t  r;
    logic [12:0] s;
    logic [12:0] e;
    logic [12:0] cur;
    logic        hit;
    r   = s_in;
    s   = 13'd0;
    e   = 13'd0;
    cur = {2'd0, minute};
    hit = 1'b0;
    if (!s_in.match_found) begin
      case (s_in.phase)
        PH_SCAN: r.error_seen = 1'b1;
        PH_MATCHED: begin
          if (s_in.colon_count == 2'd0) begin
            r.error_seen = 1'b1;
          end else begin
            if (s_in.start_time.ok && s_in.start_time.count == 3'd4) begin
              s = s_in.start_time.acc;
            end else begin
              r.error_seen = 1'b1;
            end
            if (s_in.colon_count < 2'd2) begin
              r.error_seen = 1'b1;
            end else begin
              if (s_in.end_time.ok && s_in.end_time.count == 3'd4) begin
                e = s_in.end_time.acc;
              end else begin
                r.error_seen = 1'b1;
              end
              if (e > s) begin
                hit = (cur >= s) && (cur <= e);
              end else begin
                hit = (cur >= s) || (cur <= e);
              end
              if (hit) begin
                r.match_found = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
    r.phase       = PH_SCAN;
    r.colon_count = 2'd0;
    r.start_time  = TACC_RESET;
    r.end_time    = TACC_RESET;
    return r;
  endfunction

  function automatic swm_state_t take_byte(swm_state_t s_in, logic [7:0] b, swm_cfg_t c);
    swm_state_t r;
    r = s_in;
    if (!s_in.match_found) begin
      if (b == CH_COMMA) begin
        r = close_item(s_in, c.minute);
      end else begin
        case (s_in.phase)
          PH_SCAN: begin
            if (b == CH_STAR) begin
              r.phase = PH_MATCHED;
            end else if (b == CH_UPW || b == CH_LOWW) begin
              if (c.weekday inside {[3'd1:3'd5]}) begin
                r.phase = PH_MATCHED;
              end
            end else if (b inside {[CH_ZERO:CH_SIX]}) begin
              if (b - CH_ZERO == {5'd0, c.weekday}) begin
                r.phase = PH_MATCHED;
              end
            end else if (b == CH_COLON) begin
              r.phase = PH_SKIP;
            end else begin
              r.error_seen = 1'b1;
              r.phase      = PH_SKIP;
            end
          end
          PH_MATCHED: begin
            if (s_in.colon_count == 2'd0) begin
              if (b == CH_COLON) begin
                r.colon_count = 2'd1;
              end
            end else begin
              r.start_time = take_time_char(s_in.start_time, b);
              if (s_in.colon_count == 2'd2) begin
                r.end_time = take_time_char(s_in.end_time, b);
              end else if (b == CH_COLON) begin
                r.colon_count = 2'd2;
              end
            end
          end
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  always_comb begin
    after_byte = take_byte(st, spec_byte, cfg);
    after_last = close_item(after_byte, cfg.minute);
    if (spec_absent) begin
      result.in_window  = cfg.default_result;
      result.spec_error = 1'b0;
      st_next           = STATE_RESET;
    end else if (last_byte) begin
      result.in_window  = after_last.match_found;
      result.spec_error = after_last.error_seen;
      st_next           = STATE_RESET;
    end else begin
      result            = '0;
      st_next           = after_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (step) begin
      st <= st_next;
    end
  end
endmodule

@@ rtl/core/schedule_window_matcher.sv @@
`timescale 1ns / 1ps
// Top level: input register, parse stage, result register and APB configuration.
// Throughput: one byte per cycle via the single parse stage, until the output stalls.
// The result of a last-byte or absent transaction is offered from the result register.
// The result register decouples the output; a stalled output holds one result and
// lets the input register fill before the input side stalls.
// Reset (rst, synchronous) returns parse state to its start, clears the valid flags and
// configuration registers; byte and result data registers are not reset.
module schedule_window_matcher (
  input  logic        clk,
  input  logic        rst,
  swm_in_if.sink      in_ch,
  swm_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swm_pkg::*;

  swm_cfg_t    cfg;
  swm_result_t result;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_absent;
  logic       s1_emits;
  logic       s1_fire;
  logic       in_fire;

  swm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swm_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_fire),
    .spec_byte   (s1_byte),
    .last_byte   (s1_last),
    .spec_absent (s1_absent),
    .cfg         (cfg),
    .result      (result)
  );

  assign s1_emits    = s1_last || s1_absent;
  assign s1_fire     = s1_valid && (!s1_emits || !out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte   <= in_ch.spec_byte;
      s1_last   <= in_ch.last_byte;
      s1_absent <= in_ch.spec_absent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (s1_fire && s1_emits) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emits) begin
      out_ch.in_window  <= result.in_window;
      out_ch.spec_error <= result.spec_error;
    end
  end
endmodule

@@ verif/schedule_window_matcher_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for schedule_window_matcher: random schedule texts against a predictor.
module schedule_window_matcher_test;
  import swm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_COUNT = 8;
  localparam int CHARS_PER_PHASE = 112;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       absent;
  } sched_char_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();

  schedule_window_matcher i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swm_cfg_t    cfg;
  swm_state_t  scan;
  swm_result_t verdict_q[$];
  sched_char_t text_q[$];
  sched_char_t next_char;
  logic [7:0]  text_buf[$];
  int          chars_queued;
  int          chars_taken;
  int          mismatches;
  int          send_gap_pct;
  int          stall_pct;
  int          cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Window time accumulator: one character of HHMM.
  function automatic swm_tacc_t take_time_char(swm_tacc_t t, logic [7:0] b);
    logic [12:0] weight;
    if (t.count >= 3'd4) return t;
    case (t.count[1:0])
      2'd0: weight = TEN * MIN_PER_HOUR;
      2'd1: weight = MIN_PER_HOUR;
      2'd2: weight = TEN;
      default: weight = 13'd1;
    endcase
    if (b >= CH_ZERO && b <= CH_NINE && t.ok) begin
      t.acc = t.acc + weight * (b - CH_ZERO);
    end else begin
      t.ok = 1'b0;
    end
    t.count = t.count + 3'd1;
    return t;
  endfunction

  function automatic void close_entry();
    logic [12:0] s;
    logic [12:0] e;
    logic        hit;
    logic        keep_match;
    logic        keep_error;
    if (!scan.match_found) begin
      if (scan.phase == PH_SCAN) begin
        scan.error_seen = 1'b1;
      end else if (scan.phase == PH_MATCHED) begin
        if (scan.colon_count == 2'd0) begin
          scan.error_seen = 1'b1;
        end else begin
          s = '0;
          e = '0;
          if (scan.start_time.ok && scan.start_time.count == 3'd4) begin
            s = scan.start_time.acc;
          end else begin
            scan.error_seen = 1'b1;
          end
          if (scan.colon_count < 2'd2) begin
            scan.error_seen = 1'b1;
          end else begin
            if (scan.end_time.ok && scan.end_time.count == 3'd4) begin
              e = scan.end_time.acc;
            end else begin
              scan.error_seen = 1'b1;
            end
            if (e > s) hit = (cfg.minute >= s) && (cfg.minute <= e);
            else hit = (cfg.minute >= s) || (cfg.minute <= e);
            if (hit) scan.match_found = 1'b1;
          end
        end
      end
    end
    keep_match = scan.match_found;
    keep_error = scan.error_seen;
    scan = STATE_RESET;
    scan.match_found = keep_match;
    scan.error_seen = keep_error;
  endfunction

  function automatic void scan_text_char(logic [7:0] b);
    logic [1:0] prev;
    if (scan.match_found) return;
    if (b == CH_COMMA) begin
      close_entry();
      return;
    end
    case (scan.phase)
      PH_SCAN: begin
        if (b == CH_STAR) begin
          scan.phase = PH_MATCHED;
        end else if (b == CH_UPW || b == CH_LOWW) begin
          if (cfg.weekday >= 3'd1 && cfg.weekday <= 3'd5) scan.phase = PH_MATCHED;
        end else if (b >= CH_ZERO && b <= CH_SIX) begin
          if (b - CH_ZERO == cfg.weekday) scan.phase = PH_MATCHED;
        end else if (b == CH_COLON) begin
          scan.phase = PH_SKIP;
        end else begin
          scan.error_seen = 1'b1;
          scan.phase = PH_SKIP;
        end
      end
      PH_MATCHED: begin
        prev = scan.colon_count;
        if (prev == 2'd0) begin
          if (b == CH_COLON) scan.colon_count = 2'd1;
        end else begin
          scan.start_time = take_time_char(scan.start_time, b);
          if (prev == 2'd2) scan.end_time = take_time_char(scan.end_time, b);
          else if (b == CH_COLON) scan.colon_count = 2'd2;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_window(sched_char_t c);
    if (c.absent) begin
      verdict_q.push_back('{in_window: cfg.default_result, spec_error: 1'b0});
      scan = STATE_RESET;
      return;
    end
    scan_text_char(c.ch);
    if (!c.last) return;
    close_entry();
    verdict_q.push_back('{in_window: scan.match_found, spec_error: scan.error_seen});
    scan = STATE_RESET;
  endfunction

  // Driver: offer the next pending character, predict on every accepted one.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_window('{ch: in_ch.spec_byte, last: in_ch.last_byte,
                         absent: in_ch.spec_absent});
        chars_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (text_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_char = text_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.spec_byte   <= next_char.ch;
          in_ch.last_byte   <= next_char.last;
          in_ch.spec_absent <= next_char.absent;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch("result with no prediction pending");
        end else begin
          if (out_ch.in_window !== verdict_q[0].in_window)
            flag_mismatch($sformatf("in_window %b, predicted %b", out_ch.in_window,
                                    verdict_q[0].in_window));
          if (out_ch.spec_error !== verdict_q[0].spec_error)
            flag_mismatch($sformatf("spec_error %b, predicted %b", out_ch.spec_error,
                                    verdict_q[0].spec_error));
          void'(verdict_q.pop_front());
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("schedule_window_matcher_test: FAIL");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WEEKDAY: cfg.weekday = value[2:0];
      REG_MINUTE:  cfg.minute = value[10:0];
      REG_DEFAULT: cfg.default_result = value[0];
      default: ;
    endcase
  endtask

  function automatic void queue_char(logic [7:0] ch, logic last, logic absent);
    text_q.push_back('{ch: ch, last: last, absent: absent});
    chars_queued++;
  endfunction

  function automatic void queue_string(string s);
    for (int k = 0; k < s.len(); k++) queue_char(s[k], k == s.len() - 1, 1'b0);
  endfunction

  function automatic void queue_absent();
    queue_char(8'($urandom_range(1, 255)), 1'($urandom_range(1)), 1'b1);
  endfunction

  function automatic void emit_text(bit closed);
    for (int k = 0; k < text_buf.size(); k++)
      queue_char(text_buf[k], closed && k == text_buf.size() - 1, 1'b0);
    text_buf.delete();
  endfunction

  function automatic logic [7:0] junk_char();
    if ($urandom_range(1)) return 8'h41 + 8'($urandom_range(0, 25));
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] day_char();
    int r;
    r = $urandom_range(9);
    if (r == 0) return CH_STAR;
    if (r == 1) return CH_UPW;
    if (r == 2) return CH_LOWW;
    return CH_ZERO + 8'($urandom_range(0, 6));
  endfunction

  // HHMM code, often near the configured minute so windows both hit and miss.
  function automatic int pick_time_code();
    int r;
    int m;
    r = $urandom_range(99);
    if (r < 40) begin
      m = cfg.minute;
      m = m + int'($urandom_range(0, 6)) - 3;
      if (m < 0) m = 0;
      if (m > 1439) m = 1439;
    end else if (r < 85) begin
      m = $urandom_range(0, 1439);
    end else begin
      return $urandom_range(0, 99) * 100 + $urandom_range(0, 99);
    end
    return (m / 60) * 100 + m % 60;
  endfunction

  function automatic void add_time(int code);
    logic [7:0] digs[4];
    int         r;
    int         keep;
    digs[0] = CH_ZERO + 8'(code / 1000);
    digs[1] = CH_ZERO + 8'((code / 100) % 10);
    digs[2] = CH_ZERO + 8'((code / 10) % 10);
    digs[3] = CH_ZERO + 8'(code % 10);
    r = $urandom_range(99);
    keep = 4;
    if (r < 5) keep = $urandom_range(0, 3);
    else if (r < 8) digs[$urandom_range(0, 3)] = junk_char();
    else if (r < 10) for (int k = 0; k < 4; k++) digs[k] = 8'h61 + 8'($urandom_range(0, 25));
    for (int k = 0; k < keep; k++) text_buf.push_back(digs[k]);
  endfunction

  function automatic void add_entry();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 5) return;
    n = $urandom_range(1, 3);
    for (int k = 0; k < n; k++) text_buf.push_back(day_char());
    if (kind < 10) text_buf.insert($urandom_range(0, text_buf.size()), junk_char());
    if ($urandom_range(99) >= 4) text_buf.push_back(CH_COLON);
    add_time(pick_time_code());
    if ($urandom_range(99) >= 4) text_buf.push_back(CH_COLON);
    add_time(pick_time_code());
    if ($urandom_range(99) < 4) text_buf.push_back(junk_char());
  endfunction

  function automatic void build_text();
    int n;
    n = $urandom_range(1, 3);
    if ($urandom_range(99) < 3) text_buf.push_back(CH_COMMA);
    for (int k = 0; k < n; k++) begin
      if (k != 0) text_buf.push_back(CH_COMMA);
      add_entry();
    end
    if ($urandom_range(99) < 3 || text_buf.size() == 0) text_buf.push_back(CH_COMMA);
  endfunction

  function automatic void build_noise();
    string pool;
    int    n;
    pool = ":,*Ww0123456789";
    n = $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(1)) text_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
      else text_buf.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  function automatic void fill_phase();
    int start_count;
    int r;
    start_count = chars_queued;
    while (chars_queued - start_count < CHARS_PER_PHASE) begin
      r = $urandom_range(99);
      if (r < 4) begin
        queue_absent();
      end else if (r < 7) begin
        build_text();
        if (text_buf.size() > 1) void'(text_buf.pop_back());
        emit_text(1'b0);
        queue_absent();
      end else if (r < 15) begin
        build_noise();
        emit_text(1'b1);
      end else begin
        build_text();
        emit_text(1'b1);
      end
    end
  endfunction

  task automatic drain();
    while (!(chars_taken == chars_queued && verdict_q.size() == 0)) @(posedge clk);
  endtask

  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.spec_byte   = 8'h01;
    in_ch.last_byte   = 1'b0;
    in_ch.spec_absent = 1'b0;
    out_ch.ready      = 1'b0;
    cfg               = '0;
    scan              = STATE_RESET;
    chars_queued      = 0;
    chars_taken       = 0;
    mismatches        = 0;
    send_gap_pct      = 0;
    stall_pct         = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      repeat (4) @(posedge clk);
      case (p)
        0: begin
          write_reg(REG_WEEKDAY, 32'd0);
          write_reg(REG_MINUTE, 32'd0);
          write_reg(REG_DEFAULT, 32'd0);
        end
        1: begin
          write_reg(REG_WEEKDAY, 32'd6);
          write_reg(REG_MINUTE, 32'd1439);
          write_reg(REG_DEFAULT, 32'd1);
        end
        2: begin
          write_reg(REG_WEEKDAY, 32'd7);
          write_reg(REG_MINUTE, 32'd2047);
          write_reg(REG_DEFAULT, 32'd1);
        end
        default: begin
          write_reg(REG_WEEKDAY, $urandom_range(0, 7));
          if ($urandom_range(9) == 0) write_reg(REG_MINUTE, $urandom_range(1440, 2047));
          else write_reg(REG_MINUTE, $urandom_range(0, 1439));
          write_reg(REG_DEFAULT, $urandom_range(1));
        end
      endcase
      @(negedge clk);
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 51; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 51; end
        default: begin send_gap_pct = 26; stall_pct = 26; end
      endcase
      if (p == 0) begin
        // wrap past midnight, absent with and without last mark, leading empty entry,
        // hours beyond range with a short end time, byte extremes
        queue_string("*:2300:0100");
        queue_char(8'hFF, 1'b1, 1'b1);
        queue_string(",0:9999:12");
        queue_char(8'h01, 1'b0, 1'b1);
        queue_char(8'h01, 1'b0, 1'b0);
        queue_char(8'hFF, 1'b1, 1'b0);
      end
      fill_phase();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("schedule_window_matcher_test: PASS");
    else $display("schedule_window_matcher_test: FAIL");
    $finish;
  end

endmodule
